FILE: sv/gast_pkg.sv
package gast_pkg;

    // cell status codes held in the node store
    localparam logic [1:0] ST_UNSEEN = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;

    // input beat kinds (tuser)
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic REG_STRAIGHT = 1'b0;
    localparam logic REG_DIAGONAL = 1'b1;

    localparam logic [7:0] STRAIGHT_RESET = 8'd10;
    localparam logic [7:0] DIAGONAL_RESET = 8'd14;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_DECODE,
        OP_RST_CLR,
        OP_Q_CLR,
        OP_Q_INIT,
        OP_SCAN,
        OP_CLOSE,
        OP_NB_POS,
        OP_NB_RD0,
        OP_NB_RDA,
        OP_NB_RDB,
        OP_NB_RDN,
        OP_NB_UPD,
        OP_NB_NEXT,
        OP_TR_INIT,
        OP_TR_RD,
        OP_TR_STEP,
        OP_RES_OK,
        OP_RES_FAIL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic cmd_query;
        logic in_range;
        logic scan_done;
        logic have_best;
        logic best_is_goal;
        logic nb_oob;
        logic walk_bit;
        logic nb_diag;
        logic last_dir;
        logic tr_stop;
        logic tr_poob;
        logic out_free;
    } dp_stat_t;

    // move offsets, two's complement: 2'b11 is -1
    function automatic logic [1:0] step_dx(input logic [2:0] d);
        logic [1:0] r;
        unique case (d)
            3'd0, 3'd1: r = 2'b00;
            3'd2, 3'd4, 3'd5: r = 2'b11;
            default: r = 2'b01;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] step_dy(input logic [2:0] d);
        logic [1:0] r;
        unique case (d)
            3'd0, 3'd4, 3'd6: r = 2'b11;
            3'd2, 3'd3: r = 2'b00;
            default: r = 2'b01;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/gast_ram.sv
module gast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/gast_dp.sv
module gast_dp #(
    parameter int GRID_SIZE = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gast_pkg::dp_cmd_t  cmd,
    output gast_pkg::dp_stat_t stat,
    input  logic [31:0]        s_tdata,
    input  logic               s_tuser,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,
    output logic               m_tuser
);
    import gast_pkg::*;

    localparam int CW    = $clog2(GRID_SIZE);
    localparam int NCELL = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(NCELL);
    localparam int CNTW  = $clog2(NCELL + 1);
    localparam int GW    = $clog2(255 * NCELL + 1);
    localparam int FW    = GW + 1;
    localparam int SW    = $clog2(NCELL + 1);

    typedef struct packed {
        logic [1:0]    status;
        logic [GW-1:0] g;
        logic [FW-1:0] f;
        logic [2:0]    dir;
        logic [SW-1:0] stamp;
    } node_t;

    localparam int NW = $bits(node_t);

    function automatic logic [AW-1:0] cell_at(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return AW'(int'(y) * GRID_SIZE + int'(x));
    endfunction

    // config
    logic [7:0] sc_reg, dc_reg;

    // latched beat
    logic          cmd_reg;
    logic [4:0]    wx_reg, wy_reg, qsx_reg, qsy_reg, qgx_reg, qgy_reg;
    logic          wv_reg;

    // scan
    logic [CNTW-1:0] cnt_reg;
    logic [CW-1:0]   scx_reg, scy_reg, ex_reg, ey_reg;
    logic            pend_reg, have_reg;
    node_t           best_reg;
    logic [CW-1:0]   bx_reg, by_reg;

    // neighbor
    logic [2:0]    d_reg;
    logic [CW-1:0] nx_reg, ny_reg;
    logic          oob_reg;
    logic [FW-1:0] h_reg;
    logic [SW-1:0] stamp_cnt_reg;

    // trace
    logic [CW-1:0]   tx_reg, ty_reg, ox_reg, oy_reg;
    logic [CNTW-1:0] guard_reg;

    // result
    logic       m_valid_reg, m_found_reg;
    logic [4:0] m_x_reg, m_y_reg;

    // rams
    node_t         node_rd, node_wr;
    logic          node_we, node_re;
    logic [AW-1:0] node_waddr, node_raddr;
    logic          walk_we, walk_re, walk_wd, walk_rd;
    logic [AW-1:0] walk_waddr, walk_raddr;

    logic [CW-1:0] qsx_c, qsy_c, qgx_c, qgy_c, wx_c, wy_c;
    logic          w_in_range, q_in_range, scan_live, better, out_free;
    logic [CW:0]   ndx_e, ndy_e, nx_full, ny_full, tdx_e, tdy_e, px_full, py_full;
    logic [CW-1:0] adx, ady, lo, hi;
    logic [CW+7:0] p_s, p_d;
    logic [FW-1:0] h_next;
    logic [GW-1:0] tg;
    logic          nb_new, nb_upd, tr_poob;
    logic [1:0]    sdx, sdy, tdx, tdy;

    assign qsx_c = CW'(qsx_reg);
    assign qsy_c = CW'(qsy_reg);
    assign qgx_c = CW'(qgx_reg);
    assign qgy_c = CW'(qgy_reg);
    assign wx_c  = CW'(wx_reg);
    assign wy_c  = CW'(wy_reg);

    assign w_in_range = (32'(wx_reg) < GRID_SIZE) && (32'(wy_reg) < GRID_SIZE);
    assign q_in_range = (32'(qsx_reg) < GRID_SIZE) && (32'(qsy_reg) < GRID_SIZE)
                     && (32'(qgx_reg) < GRID_SIZE) && (32'(qgy_reg) < GRID_SIZE);

    assign scan_live = cnt_reg < CNTW'(NCELL);
    // lowest f first, then oldest insert
    assign better = (node_rd.status == ST_OPEN)
                 && (!have_reg || (node_rd.f < best_reg.f)
                     || ((node_rd.f == best_reg.f) && (node_rd.stamp < best_reg.stamp)));

    assign sdx     = step_dx(d_reg);
    assign sdy     = step_dy(d_reg);
    assign ndx_e   = {{(CW-1){sdx[1]}}, sdx};
    assign ndy_e   = {{(CW-1){sdy[1]}}, sdy};
    assign nx_full = {1'b0, bx_reg} + ndx_e;
    assign ny_full = {1'b0, by_reg} + ndy_e;

    // octile distance to goal
    assign adx    = (nx_reg >= qgx_c) ? nx_reg - qgx_c : qgx_c - nx_reg;
    assign ady    = (ny_reg >= qgy_c) ? ny_reg - qgy_c : qgy_c - ny_reg;
    assign lo     = (adx < ady) ? adx : ady;
    assign hi     = (adx < ady) ? ady : adx;
    assign p_s    = sc_reg * (hi - lo);
    assign p_d    = dc_reg * lo;
    assign h_next = FW'(p_s) + FW'(p_d);

    assign tg     = best_reg.g + GW'(d_reg[2] ? dc_reg : sc_reg);
    assign nb_new = node_rd.status != ST_OPEN;
    assign nb_upd = (node_rd.status != ST_CLOSED) && (nb_new || (tg < node_rd.g));

    assign tdx     = step_dx(node_rd.dir);
    assign tdy     = step_dy(node_rd.dir);
    assign tdx_e   = {{(CW-1){tdx[1]}}, tdx};
    assign tdy_e   = {{(CW-1){tdy[1]}}, tdy};
    assign px_full = {1'b0, tx_reg} - tdx_e;
    assign py_full = {1'b0, ty_reg} - tdy_e;
    assign tr_poob = (32'(px_full) >= GRID_SIZE) || (32'(py_full) >= GRID_SIZE);

    assign out_free = !m_valid_reg || m_tready;

    // RAM port control
    always_comb
    begin
        node_we    = 1'b0;
        node_re    = 1'b0;
        node_waddr = cell_at(nx_reg, ny_reg);
        node_raddr = cell_at(nx_reg, ny_reg);
        node_wr    = '0;
        walk_we    = 1'b0;
        walk_re    = 1'b0;
        walk_wd    = 1'b1;
        walk_waddr = cnt_reg[AW-1:0];
        walk_raddr = cell_at(nx_reg, ny_reg);
        unique case (cmd.op)
            OP_RST_CLR:
            begin
                walk_we = 1'b1;
            end
            OP_DECODE:
            begin
                walk_we    = (cmd_reg == CMD_WRITE) && w_in_range;
                walk_waddr = cell_at(wx_c, wy_c);
                walk_wd    = wv_reg;
            end
            OP_Q_CLR:
            begin
                node_we        = 1'b1;
                node_waddr     = cnt_reg[AW-1:0];
                node_wr.status = ST_UNSEEN;
            end
            OP_Q_INIT:
            begin
                node_we        = 1'b1;
                node_waddr     = cell_at(qsx_c, qsy_c);
                node_wr.status = ST_OPEN;
            end
            OP_SCAN:
            begin
                node_re    = scan_live;
                node_raddr = cnt_reg[AW-1:0];
            end
            OP_CLOSE:
            begin
                node_we        = 1'b1;
                node_waddr     = cell_at(bx_reg, by_reg);
                node_wr        = best_reg;
                node_wr.status = ST_CLOSED;
            end
            OP_NB_RD0:
            begin
                walk_re = 1'b1;
            end
            OP_NB_RDA:
            begin
                walk_re    = 1'b1;
                walk_raddr = cell_at(bx_reg, ny_reg);
            end
            OP_NB_RDB:
            begin
                walk_re    = 1'b1;
                walk_raddr = cell_at(nx_reg, by_reg);
            end
            OP_NB_RDN:
            begin
                node_re = 1'b1;
            end
            OP_NB_UPD:
            begin
                node_we        = nb_upd;
                node_wr.status = ST_OPEN;
                node_wr.g      = tg;
                node_wr.f      = FW'(tg) + h_reg;
                node_wr.dir    = d_reg;
                node_wr.stamp  = nb_new ? stamp_cnt_reg : node_rd.stamp;
            end
            OP_TR_RD:
            begin
                node_re    = 1'b1;
                node_raddr = cell_at(tx_reg, ty_reg);
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg        <= STRAIGHT_RESET;
            dc_reg        <= DIAGONAL_RESET;
            cnt_reg       <= '0;
            scx_reg       <= '0;
            scy_reg       <= '0;
            pend_reg      <= 1'b0;
            have_reg      <= 1'b0;
            d_reg         <= '0;
            stamp_cnt_reg <= '0;
            guard_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_STRAIGHT)
                begin
                    sc_reg <= cfg_data;
                end
                else
                begin
                    dc_reg <= cfg_data;
                end
            end
            // read data of a scan read lands in the cycle after the read
            pend_reg <= (cmd.op == OP_SCAN) && scan_live;
            if ((cmd.op == OP_RES_OK) || (cmd.op == OP_RES_FAIL))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_RST_CLR, OP_Q_CLR:
                begin
                    cnt_reg <= stat.sweep_last ? '0 : cnt_reg + 1'b1;
                end
                OP_DECODE:
                begin
                    cnt_reg <= '0;
                end
                OP_Q_INIT, OP_NB_NEXT:
                begin
                    cnt_reg  <= '0;
                    scx_reg  <= '0;
                    scy_reg  <= '0;
                    have_reg <= 1'b0;
                    if (cmd.op == OP_Q_INIT)
                    begin
                        stamp_cnt_reg <= SW'(1);
                    end
                    else
                    begin
                        d_reg <= d_reg + 1'b1;
                    end
                end
                OP_SCAN:
                begin
                    if (scan_live)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (32'(scx_reg) == GRID_SIZE - 1)
                        begin
                            scx_reg <= '0;
                            scy_reg <= scy_reg + 1'b1;
                        end
                        else
                        begin
                            scx_reg <= scx_reg + 1'b1;
                        end
                    end
                    if (pend_reg && better)
                    begin
                        have_reg <= 1'b1;
                    end
                end
                OP_CLOSE:
                begin
                    d_reg <= '0;
                end
                OP_NB_UPD:
                begin
                    if (nb_upd && nb_new)
                    begin
                        stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
                    end
                end
                OP_TR_INIT:
                begin
                    guard_reg <= '0;
                end
                OP_TR_STEP:
                begin
                    if (!tr_poob)
                    begin
                        guard_reg <= guard_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_ACCEPT:
            begin
                cmd_reg <= s_tuser;
                wx_reg  <= s_tdata[4:0];
                wy_reg  <= s_tdata[9:5];
                wv_reg  <= s_tdata[10];
                qsx_reg <= s_tdata[15:11];
                qsy_reg <= s_tdata[20:16];
                qgx_reg <= s_tdata[25:21];
                qgy_reg <= s_tdata[30:26];
            end
            OP_SCAN:
            begin
                if (scan_live)
                begin
                    ex_reg <= scx_reg;
                    ey_reg <= scy_reg;
                end
                if (pend_reg && better)
                begin
                    best_reg <= node_rd;
                    bx_reg   <= ex_reg;
                    by_reg   <= ey_reg;
                end
            end
            OP_NB_POS:
            begin
                nx_reg  <= nx_full[CW-1:0];
                ny_reg  <= ny_full[CW-1:0];
                oob_reg <= (32'(nx_full) >= GRID_SIZE) || (32'(ny_full) >= GRID_SIZE);
            end
            OP_NB_RD0:
            begin
                h_reg <= h_next;
            end
            OP_TR_INIT:
            begin
                tx_reg <= bx_reg;
                ty_reg <= by_reg;
                ox_reg <= qsx_c;
                oy_reg <= qsy_c;
            end
            OP_TR_STEP:
            begin
                ox_reg <= tx_reg;
                oy_reg <= ty_reg;
                if (!tr_poob)
                begin
                    tx_reg <= px_full[CW-1:0];
                    ty_reg <= py_full[CW-1:0];
                end
            end
            OP_RES_OK:
            begin
                m_found_reg <= 1'b1;
                m_x_reg     <= 5'(ox_reg);
                m_y_reg     <= 5'(oy_reg);
            end
            OP_RES_FAIL:
            begin
                m_found_reg <= 1'b0;
                m_x_reg     <= '0;
                m_y_reg     <= '0;
            end
            default:
            begin
            end
        endcase
    end

    gast_ram #(.WIDTH(NW), .DEPTH(NCELL)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wr),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rd)
    );

    gast_ram #(.WIDTH(1), .DEPTH(NCELL)) u_walk_ram (
        .clk   (clk),
        .we    (walk_we),
        .waddr (walk_waddr),
        .wdata (walk_wd),
        .re    (walk_re),
        .raddr (walk_raddr),
        .rdata (walk_rd)
    );

    assign stat.sweep_last   = cnt_reg == CNTW'(NCELL - 1);
    assign stat.cmd_query    = cmd_reg == CMD_QUERY;
    assign stat.in_range     = q_in_range;
    assign stat.scan_done    = !scan_live && !pend_reg;
    assign stat.have_best    = have_reg;
    assign stat.best_is_goal = (bx_reg == qgx_c) && (by_reg == qgy_c);
    assign stat.nb_oob       = oob_reg;
    assign stat.walk_bit     = walk_rd;
    assign stat.nb_diag      = d_reg[2];
    assign stat.last_dir     = d_reg == 3'd7;
    assign stat.tr_stop      = ((tx_reg == qsx_c) && (ty_reg == qsy_c))
                            || (guard_reg == CNTW'(NCELL));
    assign stat.tr_poob      = tr_poob;
    assign stat.out_free     = out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {6'd0, m_y_reg, m_x_reg};

    a_stamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stamp_cnt_reg <= SW'(NCELL))
        else $error("insert stamp counter past cell count");

    a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
        guard_reg <= CNTW'(NCELL))
        else $error("trace guard past cell count");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RES_OK || cmd.op == OP_RES_FAIL) |-> out_free)
        else $error("result loaded over a pending beat");

    a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(cmd.op) == OP_SCAN)
        else $error("scan read pending outside a scan");

endmodule

FILE: sv/gast_ctrl.sv
module gast_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  gast_pkg::dp_stat_t stat,
    output gast_pkg::dp_cmd_t  cmd
);
    import gast_pkg::*;

    typedef enum logic [4:0] {
        S_RST_CLR,
        S_IDLE,
        S_DECODE,
        S_Q_CLR,
        S_Q_INIT,
        S_SCAN,
        S_PICK,
        S_CLOSE,
        S_NB_POS,
        S_NB_RD0,
        S_NB_W0,
        S_NB_WA,
        S_NB_WB,
        S_NB_N,
        S_NB_NEXT,
        S_TR_INIT,
        S_TR_RD,
        S_TR_STEP,
        S_OK,
        S_FAIL
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_RST_CLR:
            begin
                cmd.op = OP_RST_CLR;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.op = OP_DECODE;
                priority if (!stat.cmd_query)
                    state_next = S_IDLE;
                else if (stat.in_range)
                    state_next = S_Q_CLR;
                else
                    state_next = S_FAIL;
            end
            S_Q_CLR:
            begin
                cmd.op = OP_Q_CLR;
                if (stat.sweep_last)
                begin
                    state_next = S_Q_INIT;
                end
            end
            S_Q_INIT:
            begin
                cmd.op     = OP_Q_INIT;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (stat.scan_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                priority if (!stat.have_best)
                    state_next = S_FAIL;
                else if (stat.best_is_goal)
                    state_next = S_TR_INIT;
                else
                    state_next = S_CLOSE;
            end
            S_CLOSE:
            begin
                cmd.op     = OP_CLOSE;
                state_next = S_NB_POS;
            end
            S_NB_POS:
            begin
                cmd.op     = OP_NB_POS;
                state_next = S_NB_RD0;
            end
            S_NB_RD0:
            begin
                if (stat.nb_oob)
                begin
                    state_next = S_NB_NEXT;
                end
                else
                begin
                    cmd.op     = OP_NB_RD0;
                    state_next = S_NB_W0;
                end
            end
            S_NB_W0:
            begin
                priority if (!stat.walk_bit)
                    state_next = S_NB_NEXT;
                else if (stat.nb_diag)
                begin
                    cmd.op     = OP_NB_RDA;
                    state_next = S_NB_WA;
                end
                else
                begin
                    cmd.op     = OP_NB_RDN;
                    state_next = S_NB_N;
                end
            end
            S_NB_WA:
            begin
                if (!stat.walk_bit)
                begin
                    state_next = S_NB_NEXT;
                end
                else
                begin
                    cmd.op     = OP_NB_RDB;
                    state_next = S_NB_WB;
                end
            end
            S_NB_WB:
            begin
                if (!stat.walk_bit)
                begin
                    state_next = S_NB_NEXT;
                end
                else
                begin
                    cmd.op     = OP_NB_RDN;
                    state_next = S_NB_N;
                end
            end
            S_NB_N:
            begin
                cmd.op     = OP_NB_UPD;
                state_next = S_NB_NEXT;
            end
            S_NB_NEXT:
            begin
                cmd.op     = OP_NB_NEXT;
                state_next = stat.last_dir ? S_SCAN : S_NB_POS;
            end
            S_TR_INIT:
            begin
                cmd.op     = OP_TR_INIT;
                state_next = S_TR_RD;
            end
            S_TR_RD:
            begin
                if (stat.tr_stop)
                begin
                    state_next = S_OK;
                end
                else
                begin
                    cmd.op     = OP_TR_RD;
                    state_next = S_TR_STEP;
                end
            end
            S_TR_STEP:
            begin
                cmd.op     = OP_TR_STEP;
                state_next = stat.tr_poob ? S_OK : S_TR_RD;
            end
            S_OK:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_RES_OK;
                    state_next = S_IDLE;
                end
            end
            S_FAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_RES_FAIL;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = state_reg == S_IDLE;

endmodule

FILE: sv/grid_astar_next_step.sv
// 8-way A* next-step finder on a GRID_SIZE x GRID_SIZE walkability map.
// Input stream (s_*): one beat is either a map write (tuser = 0) that sets
// one cell, or a path query (tuser = 1) from a start to a goal cell.
// Output stream (m_*): one beat per query, none per write; tuser is the
// found flag, tdata holds the first cell to step to (0,0 when not found).
// Config port: cfg_we/cfg_index/cfg_data write straight (0) and diagonal
// (1) move costs; write only while the block is idle.
// A query first clears the node store, then per expanded cell does one full
// scan of the node store (one read port) plus the neighbor work, then walks
// the traced path back cell by cell.
// Reset: the map is swept to all walkable, one cell a cycle; s_tready stays
// low until the sweep ends.
// A result beat waits in the output register while m_tready is low; the
// next beat is still taken, but a query finishing behind it holds until
// the output register frees up.
module grid_astar_next_step #(
    parameter int GRID_SIZE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] cell_x, [9:5] cell_y, [10] cell_walkable, [15:11] start_x,
    // [20:16] start_y, [25:21] goal_x, [30:26] goal_y, [31] zero
    input  logic [31:0] s_tdata,
    // [0] cmd
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] next_x, [9:5] next_y, [15:10] zero
    output logic [15:0] m_tdata,
    // [0] found
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import gast_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: reset sweep, query clear, scan / expand / trace
    gast_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // map and node stores, search registers, result register
    gast_dp #(.GRID_SIZE(GRID_SIZE)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: dv/grid_astar_next_step_test.sv
module grid_astar_next_step_test;

    timeunit 1ns;
    timeprecision 1ps;

    import gast_pkg::*;

    localparam int GRID = 32;
    localparam int CELLS = GRID * GRID;
    // a random query is redrawn until its search expands at most this many
    // cells; each expansion costs a full node-store scan in the block
    localparam int EXPAND_CAP = 20;
    localparam longint CYCLE_LIMIT = 20000000;

    // move table, same order as the block's direction codes
    const int STEP_DX [8] = '{0, 0, -1, 1, -1, -1, 1, 1};
    const int STEP_DY [8] = '{-1, 1, 0, 0, -1, 1, -1, 1};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    grid_astar_next_step #(.GRID_SIZE(GRID)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // one step answer: found flag and first cell on the path
    typedef struct packed {
        logic       found;
        logic [4:0] nx;
        logic [4:0] ny;
    } step_t;

    // directed row: for a map write a = cell, walk = new bit; for a query
    // a = start, b = goal. known = 1 means the answer is typed in below.
    typedef struct packed {
        logic       cmd;
        logic [4:0] ax;
        logic [4:0] ay;
        logic [4:0] bx;
        logic [4:0] by;
        logic       walk;
        logic       known;
        logic       found;
        logic [4:0] nx;
        logic [4:0] ny;
    } row_t;

    localparam logic W = CMD_WRITE;
    localparam logic Q = CMD_QUERY;

    row_t plan [23] = '{
        // open map, reset costs
        '{Q, 5'd0,  5'd0,  5'd0,  5'd0,  1'b0, 1'b1, 1'b1, 5'd0,  5'd0},   // start == goal
        '{Q, 5'd0,  5'd0,  5'd1,  5'd1,  1'b0, 1'b1, 1'b1, 5'd1,  5'd1},   // one diagonal
        '{Q, 5'd31, 5'd31, 5'd30, 5'd30, 1'b0, 1'b1, 1'b1, 5'd30, 5'd30},
        '{Q, 5'd0,  5'd0,  5'd31, 5'd31, 1'b0, 1'b0, 1'b0, 5'd0,  5'd0},   // corner to corner
        // wall off the 2x2 corner at the origin
        '{W, 5'd2,  5'd0,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 5'd0,  5'd0},
        '{W, 5'd2,  5'd1,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 5'd0,  5'd0},
        '{W, 5'd2,  5'd2,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 5'd0,  5'd0},
        '{W, 5'd1,  5'd2,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 5'd0,  5'd0},
        '{W, 5'd0,  5'd2,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 5'd0,  5'd0},
        '{Q, 5'd0,  5'd0,  5'd31, 5'd31, 1'b0, 1'b1, 1'b0, 5'd0,  5'd0},   // no path
        '{Q, 5'd0,  5'd0,  5'd2,  5'd2,  1'b0, 1'b1, 1'b0, 5'd0,  5'd0},   // goal blocked
        '{Q, 5'd2,  5'd1,  5'd3,  5'd1,  1'b0, 1'b1, 1'b1, 5'd3,  5'd1},   // start blocked
        '{Q, 5'd2,  5'd1,  5'd2,  5'd1,  1'b0, 1'b1, 1'b1, 5'd2,  5'd1},   // blocked, same cell
        '{Q, 5'd1,  5'd1,  5'd3,  5'd3,  1'b0, 1'b1, 1'b0, 5'd0,  5'd0},
        // opening the corner cell alone leaves the diagonal cut off
        '{W, 5'd2,  5'd2,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 5'd0,  5'd0},
        '{Q, 5'd1,  5'd1,  5'd3,  5'd3,  1'b0, 1'b1, 1'b0, 5'd0,  5'd0},
        '{W, 5'd1,  5'd2,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 5'd0,  5'd0},
        '{Q, 5'd1,  5'd1,  5'd3,  5'd3,  1'b0, 1'b0, 1'b0, 5'd0,  5'd0},
        '{W, 5'd2,  5'd0,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 5'd0,  5'd0},
        '{W, 5'd2,  5'd1,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 5'd0,  5'd0},
        '{W, 5'd31, 5'd31, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 5'd0,  5'd0},
        '{Q, 5'd30, 5'd30, 5'd31, 5'd31, 1'b0, 1'b1, 1'b0, 5'd0,  5'd0},
        '{W, 5'd31, 5'd31, 5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 5'd0,  5'd0}
    };

    // shadow of the block: map, costs and per-query search scratch
    bit       map_walk [CELLS];
    int       cost_straight;
    int       cost_diag;
    int       g_cost [CELLS];
    int       f_est [CELLS];
    int       order_stamp [CELLS];
    bit [2:0] from_dir [CELLS];
    bit [1:0] node_state [CELLS];

    step_t pending_steps [$];
    int    errors;
    bit    quiet;          // no idling on either side
    int    hold_cycles;    // long receiver hold, counted down by the receiver
    longint cycles;

    function automatic int octile(int ax, int ay, int bx, int by);
        int dx, dy, lo, hi;
        dx = ax > bx ? ax - bx : bx - ax;
        dy = ay > by ? ay - by : by - ay;
        lo = dx < dy ? dx : dy;
        hi = dx < dy ? dy : dx;
        return cost_straight * (hi - lo) + cost_diag * lo;
    endfunction

    // A* from start to goal; also returns the number of expanded cells
    function automatic void search_step(input int sx, input int sy, input int gx,
                                        input int gy, output step_t res,
                                        output int expanded);
        int start, best, cx, cy, nx, ny, n, tg, stamp_next, node, x, y, px, py;
        res = '0;
        expanded = 0;
        start = sy * GRID + sx;
        foreach (node_state[i]) node_state[i] = ST_UNSEEN;
        stamp_next = 0;
        g_cost[start] = 0;
        f_est[start] = 0;
        from_dir[start] = 0;
        order_stamp[start] = stamp_next++;
        node_state[start] = ST_OPEN;
        forever begin
            best = -1;
            for (int i = 0; i < CELLS; i++) begin
                if (node_state[i] != ST_OPEN) continue;
                if (best < 0 || f_est[i] < f_est[best] ||
                    (f_est[i] == f_est[best] && order_stamp[i] < order_stamp[best]))
                    best = i;
            end
            if (best < 0) return;
            expanded++;
            cx = best % GRID;
            cy = best / GRID;
            if (cx == gx && cy == gy) begin
                res.found = 1'b1;
                res.nx = sx[4:0];
                res.ny = sy[4:0];
                node = best;
                for (int k = 0; k < CELLS && node != start; k++) begin
                    x = node % GRID;
                    y = node / GRID;
                    px = x - STEP_DX[from_dir[node]];
                    py = y - STEP_DY[from_dir[node]];
                    res.nx = x[4:0];
                    res.ny = y[4:0];
                    if (px < 0 || py < 0 || px >= GRID || py >= GRID) break;
                    node = py * GRID + px;
                end
                return;
            end
            node_state[best] = ST_CLOSED;
            for (int d = 0; d < 8; d++) begin
                nx = cx + STEP_DX[d];
                ny = cy + STEP_DY[d];
                if (nx < 0 || ny < 0 || nx >= GRID || ny >= GRID) continue;
                n = ny * GRID + nx;
                if (!map_walk[n]) continue;
                // no corner cutting past an obstacle
                if (d >= 4 && (!map_walk[ny * GRID + cx] || !map_walk[cy * GRID + nx]))
                    continue;
                if (node_state[n] == ST_CLOSED) continue;
                tg = g_cost[best] + (d >= 4 ? cost_diag : cost_straight);
                if (node_state[n] != ST_OPEN || tg < g_cost[n]) begin
                    g_cost[n] = tg;
                    f_est[n] = tg + octile(nx, ny, gx, gy);
                    from_dir[n] = d[2:0];
                    if (node_state[n] != ST_OPEN) begin
                        node_state[n] = ST_OPEN;
                        order_stamp[n] = stamp_next++;
                    end
                end
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // input side: one beat per call; the unused fields carry random junk
    // ---------------------------------------------------------------
    task automatic send_beat(input logic cmd, input int ax, input int ay, input int bx,
                             input int by, input logic walk, input bit use_typed,
                             input step_t typed);
        logic [31:0] word;
        step_t res;
        int nexp;
        word = $urandom;
        word[31] = 1'b0;
        if (cmd == CMD_WRITE) begin
            word[4:0] = ax[4:0];
            word[9:5] = ay[4:0];
            word[10] = walk;
        end else begin
            word[15:11] = ax[4:0];
            word[20:16] = ay[4:0];
            word[25:21] = bx[4:0];
            word[30:26] = by[4:0];
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= word;
        do @(posedge clk); while (!s_tready);
        if (cmd == CMD_WRITE) begin
            map_walk[ay * GRID + ax] = walk;
        end else begin
            search_step(ax, ay, bx, by, res, nexp);
            pending_steps.push_back(use_typed ? typed : res);
        end
        // random gap after the beat; otherwise valid stays high into the next
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge clk);
        // a trailing map write may still be in flight
        repeat (8) @(posedge clk);
    endtask

    task automatic set_costs(input int st, input int dg);
        cfg_we <= 1'b1;
        cfg_index <= REG_STRAIGHT;
        cfg_data <= st[7:0];
        @(posedge clk);
        cfg_index <= REG_DIAGONAL;
        cfg_data <= dg[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cost_straight = st;
        cost_diag = dg;
    endtask

    function automatic int near_coord(int c);
        int v;
        v = c + $urandom_range(0, 8) - 4;
        return v < 0 ? 0 : (v > GRID - 1 ? GRID - 1 : v);
    endfunction

    // random beat: map writes mostly in a small window so obstacles cluster;
    // queries are redrawn until the search stays short
    task automatic random_beat();
        int sx, sy, gx, gy, nexp, tries;
        step_t res;
        if ($urandom_range(0, 99) < 45) begin
            if ($urandom_range(0, 9) < 7) begin
                sx = $urandom_range(0, 7);
                sy = $urandom_range(0, 7);
            end else begin
                sx = $urandom_range(0, GRID - 1);
                sy = $urandom_range(0, GRID - 1);
            end
            send_beat(CMD_WRITE, sx, sy, 0, 0, $urandom_range(0, 99) < 60 ? 1'b0 : 1'b1,
                      1'b0, '0);
        end else begin
            tries = 0;
            do begin
                if ($urandom_range(0, 9) < 7) begin
                    sx = $urandom_range(0, 7);
                    sy = $urandom_range(0, 7);
                end else begin
                    sx = $urandom_range(0, GRID - 1);
                    sy = $urandom_range(0, GRID - 1);
                end
                if ($urandom_range(0, 9) < 8) begin
                    gx = near_coord(sx);
                    gy = near_coord(sy);
                end else begin
                    gx = $urandom_range(0, GRID - 1);
                    gy = $urandom_range(0, GRID - 1);
                end
                search_step(sx, sy, gx, gy, res, nexp);
                tries++;
                if (tries > 60) begin
                    gx = sx;
                    gy = sy;
                    nexp = 0;
                end
            end while (nexp > EXPAND_CAP);
            send_beat(CMD_QUERY, sx, sy, gx, gy, 1'b0, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // output side: random stalls plus one long hold
    // ---------------------------------------------------------------
    initial begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result check against the oldest expectation
    initial begin
        step_t want;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                if (pending_steps.size() == 0) begin
                    $display("%0t: unexpected result beat found=%0b x=%0d y=%0d", $realtime,
                             m_tuser, m_tdata[4:0], m_tdata[9:5]);
                    errors++;
                end else begin
                    want = pending_steps.pop_front();
                    if (m_tuser !== want.found) begin
                        $display("%0t: found expected %0b actual %0b", $realtime, want.found,
                                 m_tuser);
                        errors++;
                    end
                    if (m_tdata[4:0] !== want.nx) begin
                        $display("%0t: next_x expected %0d actual %0d", $realtime, want.nx,
                                 m_tdata[4:0]);
                        errors++;
                    end
                    if (m_tdata[9:5] !== want.ny) begin
                        $display("%0t: next_y expected %0d actual %0d", $realtime, want.ny,
                                 m_tdata[9:5]);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog; the reset sweep and every search fit well inside
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("grid_astar_next_step_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        step_t typed;
        int phase_st [4] = '{1, 255, 255, 1};
        int phase_dg [4] = '{255, 1, 255, 1};
        errors = 0;
        quiet = 1'b0;
        hold_cycles = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_WRITE;
        cfg_we = 1'b0;
        cfg_index = REG_STRAIGHT;
        cfg_data = '0;
        foreach (map_walk[i]) map_walk[i] = 1'b1;
        cost_straight = STRAIGHT_RESET;
        cost_diag = DIAGONAL_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset costs
        foreach (plan[i]) begin
            typed.found = plan[i].found;
            typed.nx = plan[i].nx;
            typed.ny = plan[i].ny;
            send_beat(plan[i].cmd, plan[i].ax, plan[i].ay, plan[i].bx, plan[i].by,
                      plan[i].walk, plan[i].known, typed);
        end
        wait_drained();

        // random phases over several cost settings, extremes included
        for (int p = 0; p < 5; p++) begin
            if (p < 4) set_costs(phase_st[p], phase_dg[p]);
            else set_costs($urandom_range(1, 255), $urandom_range(1, 255));
            quiet = (p == 4);
            // long hold on the output so the block backs up its input; it spans
            // several whole queries, each at least two node-store sweeps long
            if (p == 1) hold_cycles = 100000;
            for (int k = 0; k < 18; k++) begin
                // once, let every result come back before going on
                if (p == 2 && k == 9) wait_drained();
                random_beat();
            end
            wait_drained();
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("grid_astar_next_step_test OK");
        else
            $display("grid_astar_next_step_test NOT OK");
        $finish;
    end

endmodule
